// ===== rtl/magnetometer_minmax_calibrator_assert.svh =====
// assertion macros for the magnetometer min/max calibrator
// no dependencies; taken in by the files that carry assertions
`ifndef MAGNETOMETER_MINMAX_CALIBRATOR_ASSERT_SVH
`define MAGNETOMETER_MINMAX_CALIBRATOR_ASSERT_SVH

// condition must hold at every edge out of reset
`define MMCAL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("calibrator assertion failed");

// consequent must hold in the same cycle as the antecedent
`define MMCAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calibrator assertion failed");

// consequent must hold in the cycle after the antecedent
`define MMCAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calibrator assertion failed");

`endif

// ===== rtl/mmcal_pkg.sv =====
// shared constants of the magnetometer min/max calibrator
// no dependencies; imported by every module of the block
package mmcal_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int INT_BITS        = 4;

   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WIDEN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COEF    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CORRECT = 2'd3;

   localparam logic [STATUS_W-1:0] ST_CORRECTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RECORDED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_READY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEGEN     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SAT       = 3'd4;

endpackage

// ===== rtl/mmcal_div.sv =====
// bit-serial restoring divider for the scale ratio (range_x << frac) / range_axis
// depends on mmcal_pkg; one quotient bit per cycle
module mmcal_div
   import mmcal_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SAMPLE_BITS-1:0]         dividend,
   input  logic [SAMPLE_BITS-1:0]         divisor,
   output logic                           done,
   output logic                           ovf,
   output logic [FRAC_BITS+INT_BITS-1:0]  quot
);

   localparam int SB = SAMPLE_BITS;
   localparam int FB = FRAC_BITS;
   localparam int QW = FB + INT_BITS;
   localparam int CW = $clog2(QW);
   localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SB-1:0] rem_ff, rem_in;
   logic [QW-1:0] dsr_ff, dsr_in;
   logic [SB-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic          ovf_ff, ovf_in;

   logic [SB:0]   shifted;
   logic [SB:0]   diff;
   logic          ge;

   assign shifted = {rem_ff, dsr_ff[QW-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         // quotient of 16 or more cannot be held in the integer bits
         ovf_in  = {{INT_BITS{1'b0}}, dividend} >= {divisor, {INT_BITS{1'b0}}};
         rem_in  = dividend >> INT_BITS;
         dsr_in  = {dividend[INT_BITS-1:0], {FB{1'b0}}};
         dvs_in  = divisor;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[SB-1:0] : shifted[SB-1:0];
         dsr_in  = dsr_ff << 1;
         quot_in = {quot_ff[QW-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/mmcal_mul.sv =====
// bit-serial shift-add multiplier: |offset sample| times Q4.16 scale
// depends on mmcal_pkg; one multiplicand bit consumed per cycle
module mmcal_mul
   import mmcal_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic [SAMPLE_BITS+1:0]                       mcand,
   input  logic [FRAC_BITS+INT_BITS-1:0]                mplier,
   output logic                                         done,
   output logic [SAMPLE_BITS+FRAC_BITS+INT_BITS+2:0]    prod
);

   localparam int AW = SAMPLE_BITS + 2;
   localparam int BW = FRAC_BITS + INT_BITS;
   localparam int CW = $clog2(AW);
   localparam logic [CW-1:0] CNT_LAST = CW'(AW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BW:0]   acc_ff, acc_in;
   logic [AW-1:0] asr_ff, asr_in;
   logic [BW-1:0] b_ff, b_in;

   logic [BW:0]   sum;

   assign sum = acc_ff + (asr_ff[0] ? {1'b0, b_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      asr_in  = asr_ff;
      b_in    = b_ff;
      if (start) begin
         acc_in  = '0;
         asr_in  = mcand;
         b_in    = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // low product bits shift in behind the multiplicand bits
         acc_in = {1'b0, sum[BW:1]};
         asr_in = {sum[0], asr_ff[AW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      asr_ff <= asr_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = {acc_ff, asr_ff};

endmodule

// ===== rtl/magnetometer_minmax_calibrator.sv =====
// magnetometer min/max calibrator: hard and soft iron correction on three axes
// depends on mmcal_pkg, mmcal_div, mmcal_mul and the assertion macro header
//
// Each request on the req_ channel carries a mode and one X/Y/Z sample; each
// request gives exactly one response on the rsp_ channel. Mode 0 restarts the
// min/max record, mode 1 widens it, mode 2 derives offsets for X, Y and Z and
// Q4.16 scales for Y and Z, mode 3 returns a corrected sample.
// One request is worked on at a time; req_stall is high from acceptance
// until the response has been moved into the output register.
// From acceptance, modes 0 and 1 pass through EXEC and OUT; mode 2 passes
// through EXEC, COEF, DIVY, DIVZ and OUT, and mode 3 through EXEC, MULS,
// MULY, MULZ and OUT. Mode 2 runs the serial divider once for Y and once
// for Z; mode 3 runs the serial multiplier once for Y and once for Z. The
// next request can be taken the cycle after the response is registered.
// The output register lets a new request be accepted while the previous
// response is still stalled; a finished response waits in its last state
// while rsp_stall holds the output register full.
// Reset clears the records and offsets to zero and the scales to unity,
// and leaves no response pending.
`include "magnetometer_minmax_calibrator_assert.svh"

module magnetometer_minmax_calibrator
   import mmcal_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [MODE_W-1:0]             req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_mag_x,
   input  logic signed [SAMPLE_BITS-1:0] req_mag_y,
   input  logic signed [SAMPLE_BITS-1:0] req_mag_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_z,
   output logic [STATUS_W-1:0]           rsp_status
);

   localparam int SB   = SAMPLE_BITS;
   localparam int FB   = FRAC_BITS;
   localparam int QW   = FB + INT_BITS;
   localparam int AW   = SB + 2;
   localparam int PW   = QW + 1 + AW;
   localparam int QOUT = PW - (FB + 1);

   localparam logic [QW-1:0] SCALE_ONE = QW'(1) << FB;
   localparam logic [QW-1:0] SCALE_SAT = {QW{1'b1}};
   localparam logic [SB-1:0] SMP_MIN   = {1'b1, {(SB-1){1'b0}}};
   localparam logic [SB-1:0] SMP_MAX   = {1'b0, {(SB-1){1'b1}}};

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EXEC = 4'd1;
   localparam logic [3:0] S_COEF = 4'd2;
   localparam logic [3:0] S_DIVY = 4'd3;
   localparam logic [3:0] S_DIVZ = 4'd4;
   localparam logic [3:0] S_MULS = 4'd5;
   localparam logic [3:0] S_MULY = 4'd6;
   localparam logic [3:0] S_MULZ = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic signed [SB-1:0] smp_x_ff, smp_x_in;
   logic signed [SB-1:0] smp_y_ff, smp_y_in;
   logic signed [SB-1:0] smp_z_ff, smp_z_in;

   logic signed [SB-1:0] min_ff [3];
   logic signed [SB-1:0] min_in [3];
   logic signed [SB-1:0] max_ff [3];
   logic signed [SB-1:0] max_in [3];
   logic [SB-1:0]        rng_ff [3];
   logic [SB-1:0]        rng_in [3];
   logic [QW-1:0]        scale_ff [2];
   logic [QW-1:0]        scale_in [2];
   logic signed [SB:0]   offx_ff, offx_in;
   logic signed [SB+1:0] offyz_ff [2];
   logic signed [SB+1:0] offyz_in [2];

   logic                 degen_ff, degen_in;
   logic                 sat_ff, sat_in;
   logic signed [SB+2:0] uy_ff, uy_in;
   logic signed [SB+2:0] uz_ff, uz_in;
   logic [SB-1:0]        res_x_ff, res_x_in;
   logic [SB-1:0]        res_y_ff, res_y_in;
   logic [SB-1:0]        res_z_ff, res_z_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]        rsp_x_ff, rsp_x_in;
   logic [SB-1:0]        rsp_y_ff, rsp_y_in;
   logic [SB-1:0]        rsp_z_ff, rsp_z_in;
   logic [STATUS_W-1:0]  rsp_st_ff, rsp_st_in;

   // datapath
   logic [SB:0]          rng_diff [3];
   logic signed [SB:0]   offx_calc;
   logic signed [SB+1:0] offy_calc, offz_calc;
   logic signed [SB+2:0] uy_calc, uz_calc;
   logic signed [SB+1:0] xs;
   logic                 x_ovf;
   logic [SB-1:0]        x_clip;

   logic                 div_start, div_done, div_ovf;
   logic [SB-1:0]        div_dvs, div_axis_rng;
   logic [QW-1:0]        div_q;
   logic                 div_nz;
   logic [QW-1:0]        scale_new;

   logic                 mul_start, mul_done;
   logic signed [SB+2:0] u_sel;
   logic [SB+2:0]        u_neg;
   logic [AW-1:0]        u_abs;
   logic [QW-1:0]        mul_b;
   logic [PW-1:0]        mul_p;
   logic                 clamp_neg;
   logic [QOUT-1:0]      q_raw, q_lim;
   logic                 q_over;
   logic [SB-1:0]        q_clip, q_res;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rng_diff[i] = {max_ff[i][SB-1], max_ff[i]} - {min_ff[i][SB-1], min_ff[i]};
      end
   end

   // offsets as minus the midpoint; Y/Z kept in half-units of the fraction
   assign offx_calc = {2'b00, rng_ff[0][SB-1:1]} - {max_ff[0][SB-1], max_ff[0]};
   assign offy_calc = {2'b00, rng_ff[1]} - {max_ff[1][SB-1], max_ff[1], 1'b0};
   assign offz_calc = {2'b00, rng_ff[2]} - {max_ff[2][SB-1], max_ff[2], 1'b0};

   assign uy_calc = {smp_y_ff[SB-1], smp_y_ff[SB-1], smp_y_ff, 1'b0}
                  + {offyz_ff[0][SB+1], offyz_ff[0]};
   assign uz_calc = {smp_z_ff[SB-1], smp_z_ff[SB-1], smp_z_ff, 1'b0}
                  + {offyz_ff[1][SB+1], offyz_ff[1]};

   assign xs     = {{2{smp_x_ff[SB-1]}}, smp_x_ff} + {offx_ff[SB], offx_ff};
   assign x_ovf  = !((&xs[SB+1:SB-1]) || !(|xs[SB+1:SB-1]));
   assign x_clip = x_ovf ? (xs[SB+1] ? SMP_MIN : SMP_MAX) : xs[SB-1:0];

   assign div_start    = (state_ff == S_COEF) || (state_ff == S_DIVY && div_done);
   assign div_dvs      = (state_ff == S_COEF) ? rng_ff[1] : rng_ff[2];
   assign div_axis_rng = (state_ff == S_DIVY) ? rng_ff[1] : rng_ff[2];
   assign div_nz       = (rng_ff[0] != '0) && (div_axis_rng != '0);
   assign scale_new    = !div_nz ? SCALE_ONE : (div_ovf ? SCALE_SAT : div_q);

   mmcal_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rng_ff[0]),
      .divisor  (div_dvs),
      .done     (div_done),
      .ovf      (div_ovf),
      .quot     (div_q)
   );

   assign mul_start = (state_ff == S_MULS) || (state_ff == S_MULY && mul_done);
   assign u_sel     = (state_ff == S_MULS) ? uy_ff : uz_ff;
   assign u_neg     = -u_sel;
   assign u_abs     = u_sel[SB+2] ? u_neg[SB+1:0] : u_sel[SB+1:0];
   assign mul_b     = (state_ff == S_MULS) ? scale_ff[0] : scale_ff[1];

   mmcal_mul #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (u_abs),
      .mplier (mul_b),
      .done   (mul_done),
      .prod   (mul_p)
   );

   // magnitude truncates toward zero, then clamps to the signed sample range
   assign clamp_neg = (state_ff == S_MULY) ? uy_ff[SB+2] : uz_ff[SB+2];
   assign q_raw     = mul_p[PW-1:FB+1];
   assign q_lim     = clamp_neg ? {{(QOUT-SB){1'b0}}, SMP_MIN}
                                : {{(QOUT-SB){1'b0}}, SMP_MAX};
   assign q_over    = q_raw > q_lim;
   assign q_clip    = q_over ? q_lim[SB-1:0] : q_raw[SB-1:0];
   assign q_res     = clamp_neg ? -q_clip : q_clip;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      smp_x_in     = smp_x_ff;
      smp_y_in     = smp_y_ff;
      smp_z_in     = smp_z_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rng_in       = rng_ff;
      scale_in     = scale_ff;
      offx_in      = offx_ff;
      offyz_in     = offyz_ff;
      degen_in     = degen_ff;
      sat_in       = sat_ff;
      uy_in        = uy_ff;
      uz_in        = uz_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_st_in    = rsp_st_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               smp_x_in = req_mag_x;
               smp_y_in = req_mag_y;
               smp_z_in = req_mag_z;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            sat_in = 1'b0;
            unique case (mode_ff)
               MODE_START: begin
                  min_in[0] = smp_x_ff;
                  min_in[1] = smp_y_ff;
                  min_in[2] = smp_z_ff;
                  max_in[0] = smp_x_ff;
                  max_in[1] = smp_y_ff;
                  max_in[2] = smp_z_ff;
                  state_in  = S_OUT;
               end
               MODE_WIDEN: begin
                  if (smp_x_ff < min_ff[0]) min_in[0] = smp_x_ff;
                  if (smp_y_ff < min_ff[1]) min_in[1] = smp_y_ff;
                  if (smp_z_ff < min_ff[2]) min_in[2] = smp_z_ff;
                  if (smp_x_ff > max_ff[0]) max_in[0] = smp_x_ff;
                  if (smp_y_ff > max_ff[1]) max_in[1] = smp_y_ff;
                  if (smp_z_ff > max_ff[2]) max_in[2] = smp_z_ff;
                  state_in = S_OUT;
               end
               MODE_COEF: begin
                  for (int i = 0; i < 3; i++) begin
                     rng_in[i] = rng_diff[i][SB-1:0];
                  end
                  state_in = S_COEF;
               end
               MODE_CORRECT: begin
                  res_x_in = x_clip;
                  sat_in   = x_ovf;
                  uy_in    = uy_calc;
                  uz_in    = uz_calc;
                  state_in = S_MULS;
               end
            endcase
         end
         S_COEF: begin
            offx_in     = offx_calc;
            offyz_in[0] = offy_calc;
            offyz_in[1] = offz_calc;
            degen_in    = (rng_ff[0] == '0) || (rng_ff[1] == '0) || (rng_ff[2] == '0);
            state_in    = S_DIVY;
         end
         S_DIVY: begin
            if (div_done) begin
               scale_in[0] = scale_new;
               sat_in      = sat_ff || (div_nz && div_ovf);
               state_in    = S_DIVZ;
            end
         end
         S_DIVZ: begin
            if (div_done) begin
               scale_in[1] = scale_new;
               sat_in      = sat_ff || (div_nz && div_ovf);
               state_in    = S_OUT;
            end
         end
         S_MULS: begin
            state_in = S_MULY;
         end
         S_MULY: begin
            if (mul_done) begin
               res_y_in = q_res;
               sat_in   = sat_ff || q_over;
               state_in = S_MULZ;
            end
         end
         S_MULZ: begin
            if (mul_done) begin
               res_z_in = q_res;
               sat_in   = sat_ff || q_over;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = (mode_ff == MODE_CORRECT) ? res_x_ff : '0;
               rsp_y_in     = (mode_ff == MODE_CORRECT) ? res_y_ff : '0;
               rsp_z_in     = (mode_ff == MODE_CORRECT) ? res_z_ff : '0;
               unique case (mode_ff)
                  MODE_START:   rsp_st_in = ST_RECORDED;
                  MODE_WIDEN:   rsp_st_in = ST_RECORDED;
                  MODE_COEF:    rsp_st_in = degen_ff ? ST_DEGEN
                                                     : (sat_ff ? ST_SAT : ST_READY);
                  MODE_CORRECT: rsp_st_in = sat_ff ? ST_SAT : ST_CORRECTED;
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
         scale_ff[0] <= SCALE_ONE;
         scale_ff[1] <= SCALE_ONE;
         offx_ff     <= '0;
         offyz_ff[0] <= '0;
         offyz_ff[1] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         scale_ff     <= scale_in;
         offx_ff      <= offx_in;
         offyz_ff     <= offyz_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      smp_x_ff  <= smp_x_in;
      smp_y_ff  <= smp_y_in;
      smp_z_ff  <= smp_z_in;
      rng_ff    <= rng_in;
      degen_ff  <= degen_in;
      sat_ff    <= sat_in;
      uy_ff     <= uy_in;
      uz_ff     <= uz_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_z_ff  <= res_z_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_z_ff  <= rsp_z_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = $signed(rsp_x_ff);
   assign rsp_out_y  = $signed(rsp_y_ff);
   assign rsp_out_z  = $signed(rsp_z_ff);
   assign rsp_status = rsp_st_ff;

   `MMCAL_ASSERT_IMPL(a_div_done_in_coef, clock, reset, div_done, state_ff == S_DIVY || state_ff == S_DIVZ)
   `MMCAL_ASSERT_IMPL(a_mul_done_in_corr, clock, reset, mul_done, state_ff == S_MULY || state_ff == S_MULZ)
   `MMCAL_ASSERT_NEXT(a_scale_held, clock, reset, state_ff != S_DIVY && state_ff != S_DIVZ, $stable(scale_ff[0]) && $stable(scale_ff[1]))
   `MMCAL_ASSERT_ALWAYS(a_min_not_above_max, clock, reset, min_ff[0] <= max_ff[0] && min_ff[1] <= max_ff[1] && min_ff[2] <= max_ff[2])

endmodule

// ===== tb/magnetometer_minmax_calibrator_checker.sv =====
// response checker for the magnetometer min/max calibrator: watches both channels,
// keeps its own copy of the calibration record and compares every response
// depends on mmcal_pkg for widths, mode and status codes
module magnetometer_minmax_calibrator_checker
   import mmcal_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [MODE_W-1:0]                 req_mode,
   input  logic signed [SAMPLE_BITS_DEF-1:0] req_mag_x,
   input  logic signed [SAMPLE_BITS_DEF-1:0] req_mag_y,
   input  logic signed [SAMPLE_BITS_DEF-1:0] req_mag_z,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [SAMPLE_BITS_DEF-1:0] rsp_out_x,
   input  logic signed [SAMPLE_BITS_DEF-1:0] rsp_out_y,
   input  logic signed [SAMPLE_BITS_DEF-1:0] rsp_out_z,
   input  logic [STATUS_W-1:0]               rsp_status,
   output int                                fail_count,
   output int                                pending_count
);

   localparam int     SB         = SAMPLE_BITS_DEF;
   localparam int     FB         = FRAC_BITS_DEF;
   localparam longint ONE_Q      = longint'(1) << FB;
   localparam longint SCALE_TOP  = (longint'(1) << (FB + INT_BITS)) - 1;
   localparam longint SAMPLE_TOP = (longint'(1) << (SB - 1)) - 1;
   localparam longint SAMPLE_BOT = -(longint'(1) << (SB - 1));

   typedef struct packed {
      logic signed [SB-1:0] out_x;
      logic signed [SB-1:0] out_y;
      logic signed [SB-1:0] out_z;
      logic [STATUS_W-1:0]  status;
   } calib_response_type;

   // calibration record and coefficients, mirrored from the block
   longint axis_lo[3];
   longint axis_hi[3];
   longint yz_scale[2];
   longint x_offset;
   longint yz_offset[2];

   calib_response_type expected_responses[$];
   calib_response_type oldest;

   function automatic longint clamp_to_sample(longint v, inout bit sat);
      if (v > SAMPLE_TOP) begin
         sat = 1'b1;
         return SAMPLE_TOP;
      end
      if (v < SAMPLE_BOT) begin
         sat = 1'b1;
         return SAMPLE_BOT;
      end
      return v;
   endfunction

   // offset added in Q.FB, then one Q4.FB multiply, truncated toward zero
   function automatic longint scale_axis(longint v, longint off, longint scale,
                                         inout bit sat);
      longint t;
      longint mag;
      longint q;
      longint lim;
      bit     neg;
      t   = v * ONE_Q + off;
      neg = t < 0;
      mag = neg ? -t : t;
      q   = ((mag >>> FB) * scale + (((mag & (ONE_Q - 1)) * scale) >>> FB)) >>> FB;
      lim = neg ? -SAMPLE_BOT : SAMPLE_TOP;
      if (q > lim) begin
         sat = 1'b1;
         q   = lim;
      end
      return neg ? -q : q;
   endfunction

   function automatic calib_response_type predict_response(logic [MODE_W-1:0] mode,
                                                           logic signed [SB-1:0] mx,
                                                           logic signed [SB-1:0] my,
                                                           logic signed [SB-1:0] mz);
      longint             s[3];
      longint             span[3];
      longint             q;
      longint             res_x;
      longint             res_y;
      longint             res_z;
      bit                 degen;
      bit                 sat;
      int                 i;
      calib_response_type res;
      s[0]  = mx;
      s[1]  = my;
      s[2]  = mz;
      res   = '0;
      degen = 1'b0;
      sat   = 1'b0;
      case (mode)
         MODE_START: begin
            for (i = 0; i < 3; i++) begin
               axis_lo[i] = s[i];
               axis_hi[i] = s[i];
            end
            res.status = ST_RECORDED;
         end
         MODE_WIDEN: begin
            for (i = 0; i < 3; i++) begin
               if (s[i] < axis_lo[i]) axis_lo[i] = s[i];
               if (s[i] > axis_hi[i]) axis_hi[i] = s[i];
            end
            res.status = ST_RECORDED;
         end
         MODE_COEF: begin
            for (i = 0; i < 3; i++) begin
               span[i] = axis_hi[i] - axis_lo[i];
               if (span[i] < 0) span[i] = 0;
               if (span[i] == 0) degen = 1'b1;
            end
            for (i = 0; i < 2; i++) begin
               q = ONE_Q;
               if (span[0] != 0 && span[i+1] != 0) begin
                  q = (span[0] << FB) / span[i+1];
                  if (q > SCALE_TOP) begin
                     q   = SCALE_TOP;
                     sat = 1'b1;
                  end
               end
               yz_scale[i]  = q;
               yz_offset[i] = span[i+1] * (ONE_Q / 2) - axis_hi[i+1] * ONE_Q;
            end
            x_offset   = span[0] / 2 - axis_hi[0];
            res.status = degen ? ST_DEGEN : (sat ? ST_SAT : ST_READY);
         end
         MODE_CORRECT: begin
            res_x      = clamp_to_sample(s[0] + x_offset, sat);
            res_y      = scale_axis(s[1], yz_offset[0], yz_scale[0], sat);
            res_z      = scale_axis(s[2], yz_offset[1], yz_scale[1], sat);
            res.out_x  = res_x[SB-1:0];
            res.out_y  = res_y[SB-1:0];
            res.out_z  = res_z[SB-1:0];
            res.status = sat ? ST_SAT : ST_CORRECTED;
         end
      endcase
      return res;
   endfunction

   task automatic compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            axis_lo[i] = 0;
            axis_hi[i] = 0;
         end
         yz_scale[0]  = ONE_Q;
         yz_scale[1]  = ONE_Q;
         x_offset     = 0;
         yz_offset[0] = 0;
         yz_offset[1] = 0;
         expected_responses.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: stray response, expected none, actual %0d %0d %0d status %0d",
                        $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_status);
               fail_count++;
            end else begin
               oldest = expected_responses.pop_front();
               compare_field("out_x", oldest.out_x, rsp_out_x);
               compare_field("out_y", oldest.out_y, rsp_out_y);
               compare_field("out_z", oldest.out_z, rsp_out_z);
               compare_field("status", oldest.status, rsp_status);
            end
         end
         if (req_valid && !req_stall)
            expected_responses.push_back(predict_response(req_mode, req_mag_x,
                                                          req_mag_y, req_mag_z));
      end
      pending_count = expected_responses.size();
   end

endmodule

// ===== tb/magnetometer_minmax_calibrator_tb.sv =====
// testbench top for the magnetometer min/max calibrator: clock, reset, request
// stimulus, response back-pressure, watchdog and verdict
// depends on mmcal_pkg, the calibrator and magnetometer_minmax_calibrator_checker
module magnetometer_minmax_calibrator_tb;
   import mmcal_pkg::*;

   localparam int SB            = SAMPLE_BITS_DEF;
   localparam int DIRECTED      = 25;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int QUIET_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 60;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic [MODE_W-1:0]    req_mode    = MODE_START;
   logic signed [SB-1:0] req_mag_x   = '0;
   logic signed [SB-1:0] req_mag_y   = '0;
   logic signed [SB-1:0] req_mag_z   = '0;
   logic                 rsp_stall   = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic signed [SB-1:0] rsp_out_x;
   logic signed [SB-1:0] rsp_out_y;
   logic signed [SB-1:0] rsp_out_z;
   logic [STATUS_W-1:0]  rsp_status;

   int fail_count;
   int pending_count;
   int send_idle_pct = 6;
   int recv_idle_pct = 71;
   int quiet_cycles  = 0;
   int requests_sent = 0;

   magnetometer_minmax_calibrator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_mag_x  (req_mag_x),
      .req_mag_y  (req_mag_y),
      .req_mag_z  (req_mag_z),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_status (rsp_status)
   );

   magnetometer_minmax_calibrator_checker u_response_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_mag_x     (req_mag_x),
      .req_mag_y     (req_mag_y),
      .req_mag_z     (req_mag_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // gives up once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(logic [MODE_W-1:0] mode, logic signed [SB-1:0] x,
                               logic signed [SB-1:0] y, logic signed [SB-1:0] z);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_mag_x <= x;
      req_mag_y <= y;
      req_mag_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // reading around a hard-iron centre, clipped to the sample range
   function automatic logic signed [SB-1:0] field_reading(int centre, int amp);
      int v;
      v = centre + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SB-1:0];
   endfunction

   function automatic int pick_amplitude();
      if ($urandom_range(0, 19) == 0) return 0;
      return 1 << $urandom_range(0, 15);
   endfunction

   // start, a run of widening samples, coefficients, then a few corrections
   task automatic calibration_sequence();
      int cx;
      int cy;
      int cz;
      int ax;
      int ay;
      int az;
      int widens;
      int fixes;
      cx     = int'($urandom_range(0, 16000)) - 8000;
      cy     = int'($urandom_range(0, 16000)) - 8000;
      cz     = int'($urandom_range(0, 16000)) - 8000;
      ax     = pick_amplitude();
      ay     = pick_amplitude();
      az     = pick_amplitude();
      widens = $urandom_range(1, 12);
      fixes  = $urandom_range(1, 10);
      send_request(MODE_START, field_reading(cx, ax), field_reading(cy, ay),
                   field_reading(cz, az));
      repeat (widens)
         send_request(MODE_WIDEN, field_reading(cx, ax), field_reading(cy, ay),
                      field_reading(cz, az));
      send_request(MODE_COEF, SB'($urandom), SB'($urandom), SB'($urandom));
      repeat (fixes) begin
         if ($urandom_range(0, 4) == 0)
            send_request(MODE_CORRECT, SB'($urandom), SB'($urandom), SB'($urandom));
         else
            send_request(MODE_CORRECT, field_reading(cx, ax), field_reading(cy, ay),
                         field_reading(cz, az));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // coefficients straight out of reset: every range is zero
      send_request(MODE_COEF, 16'sd0, 16'sd0, 16'sd0);
      send_request(MODE_CORRECT, 16'sd1234, -16'sd1234, 16'sd32767);
      // widening with no start grows from the reset record
      send_request(MODE_WIDEN, 16'sd100, -16'sd200, 16'sd300);
      send_request(MODE_COEF, 16'sd0, 16'sd0, 16'sd0);
      send_request(MODE_CORRECT, 16'sd0, 16'sd0, 16'sd0);
      // full-scale ranges on every axis
      send_request(MODE_START, -16'sd32768, -16'sd32768, -16'sd32768);
      send_request(MODE_WIDEN, 16'sd32767, 16'sd32767, 16'sd32767);
      send_request(MODE_COEF, -16'sd1, -16'sd1, -16'sd1);
      send_request(MODE_CORRECT, 16'sd32767, -16'sd32768, 16'sd32767);
      send_request(MODE_CORRECT, -16'sd32768, 16'sd32767, -16'sd32768);
      // scale ratio far beyond the Q4.16 range, then a saturating and a small correction
      send_request(MODE_START, -16'sd32768, 16'sd0, 16'sd0);
      send_request(MODE_WIDEN, 16'sd32767, 16'sd1, -16'sd1);
      send_request(MODE_COEF, 16'sd0, 16'sd0, 16'sd0);
      send_request(MODE_CORRECT, 16'sd32767, 16'sd32767, -16'sd32768);
      send_request(MODE_CORRECT, 16'sd0, 16'sd0, 16'sd0);
      // zero X range
      send_request(MODE_START, 16'sd5, -16'sd7, 16'sd9);
      send_request(MODE_WIDEN, 16'sd5, 16'sd100, -16'sd50);
      send_request(MODE_COEF, 16'sd0, 16'sd0, 16'sd0);
      // zero Y range
      send_request(MODE_START, 16'sd0, 16'sd3, -16'sd4);
      send_request(MODE_WIDEN, 16'sd1000, 16'sd3, 16'sd100);
      send_request(MODE_COEF, 16'sd0, 16'sd0, 16'sd0);
      // ordinary calibration; a Y scale ratio of exactly 16 saturates, Z stays moderate
      send_request(MODE_START, -16'sd2000, -16'sd100, -16'sd300);
      send_request(MODE_WIDEN, 16'sd2000, 16'sd150, 16'sd700);
      send_request(MODE_COEF, 16'sd0, 16'sd0, 16'sd0);
      send_request(MODE_CORRECT, 16'sd1, -16'sd1, 16'sd0);

      while (requests_sent < DIRECTED + RANDOM_ITEMS) begin
         if (requests_sent >= DIRECTED + 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (requests_sent >= DIRECTED + RANDOM_ITEMS / 3) begin
            send_idle_pct = 71;
            recv_idle_pct = 6;
         end
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4))
               send_request(MODE_W'($urandom_range(0, 3)), SB'($urandom),
                            SB'($urandom), SB'($urandom));
         end else begin
            calibration_sequence();
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== magnetometer_minmax_calibrator.f =====
+incdir+rtl
rtl/mmcal_pkg.sv
rtl/mmcal_div.sv
rtl/mmcal_mul.sv
rtl/magnetometer_minmax_calibrator.sv
tb/magnetometer_minmax_calibrator_checker.sv
tb/magnetometer_minmax_calibrator_tb.sv
